// File: hdl/egcd_pkg.sv
// ----------------------------------------------------------------------------
// Extended GCD package
// Shared widths, sequencer states and the status bundle of the divide unit.
// ----------------------------------------------------------------------------
package egcd_pkg;

   localparam int DEFAULT_OPERAND_WIDTH = 31;
   localparam int COEFF_WIDTH           = 32;
   localparam int DIVISOR_WIDTH         = 31;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE
   } egcd_state_type;

   // Status of the shared divide / multiply-accumulate unit.
   typedef struct packed {
      logic active;
      logic done;
   } egcd_div_stat_type;

endpackage

// File: hdl/egcd_divmac.sv
// ----------------------------------------------------------------------------
// Extended GCD divide and multiply-accumulate unit
// Restoring division, one quotient bit per cycle, MSB first. Each quotient
// bit is folded into two running products q*a and q*b (Horner form).
// ----------------------------------------------------------------------------
module egcd_divmac
   import egcd_pkg::*;
#(
   parameter int OPERAND_WIDTH = DEFAULT_OPERAND_WIDTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [OPERAND_WIDTH-1:0] dividend,
   input  logic [OPERAND_WIDTH-1:0] divisor,
   input  logic [COEFF_WIDTH-1:0]   mul_first,
   input  logic [COEFF_WIDTH-1:0]   mul_second,
   output egcd_div_stat_type        stat,
   output logic [OPERAND_WIDTH-1:0] remainder,
   output logic [COEFF_WIDTH-1:0]   prod_first,
   output logic [COEFF_WIDTH-1:0]   prod_second
);

   localparam int CNT_WIDTH = $clog2(OPERAND_WIDTH + 1);

   logic                     active_ff, active_in;
   logic                     done_ff, done_in;
   logic [CNT_WIDTH-1:0]     cnt_ff, cnt_in;
   logic [OPERAND_WIDTH-1:0] rem_ff, rem_in;
   logic [OPERAND_WIDTH-1:0] dvd_ff, dvd_in;
   logic [COEFF_WIDTH-1:0]   pa_ff, pa_in;
   logic [COEFF_WIDTH-1:0]   pb_ff, pb_in;

   logic [OPERAND_WIDTH:0]   trial;
   logic                     qbit;
   logic                     last_step;

   always_comb begin
      trial     = {rem_ff, dvd_ff[OPERAND_WIDTH-1]} - {1'b0, divisor};
      qbit      = ~trial[OPERAND_WIDTH];
      last_step = active_ff && (cnt_ff == CNT_WIDTH'(1));

      active_in = active_ff;
      done_in   = last_step;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      dvd_in    = dvd_ff;
      pa_in     = pa_ff;
      pb_in     = pb_ff;

      if (start) begin
         active_in = 1'b1;
         cnt_in    = CNT_WIDTH'(OPERAND_WIDTH);
         rem_in    = '0;
         dvd_in    = dividend;
         pa_in     = '0;
         pb_in     = '0;
      end else if (active_ff) begin
         cnt_in = cnt_ff - CNT_WIDTH'(1);
         dvd_in = {dvd_ff[OPERAND_WIDTH-2:0], 1'b0};
         if (qbit) begin
            rem_in = trial[OPERAND_WIDTH-1:0];
         end else begin
            rem_in = {rem_ff[OPERAND_WIDTH-2:0], dvd_ff[OPERAND_WIDTH-1]};
         end
         pa_in = {pa_ff[COEFF_WIDTH-2:0], 1'b0} + (qbit ? mul_first : '0);
         pb_in = {pb_ff[COEFF_WIDTH-2:0], 1'b0} + (qbit ? mul_second : '0);
         if (last_step) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      pa_ff  <= pa_in;
      pb_ff  <= pb_in;
   end

   assign stat.active = active_ff;
   assign stat.done   = done_ff;
   assign remainder   = rem_ff;
   assign prod_first  = pa_ff;
   assign prod_second = pb_ff;

endmodule

// File: hdl/extended_gcd_bezout_core.sv
// ----------------------------------------------------------------------------
// Extended GCD core with Bezout coefficients
// Computes d = gcd(a, b) and x, y with a*x + b*y = d, one item at a time.
// ----------------------------------------------------------------------------
// Usage: an item (req_first_value, req_second_value) is taken at a rising
// edge where start is high and busy is low. busy then stays high until the
// result has been produced. The result appears on rsp_coeff_first,
// rsp_coeff_second and rsp_divisor_out for exactly one cycle, marked by
// rsp_valid; the receiver has no way to hold it off, so it must sample it.
// Rounds: an item takes R Euclid rounds (R = number of non-zero remainders
// met, including the second operand itself). Each round is a check step,
// a pass through the shared restoring divider (one quotient bit per cycle,
// which also accumulates q*x and q*y) and an update step. For 31-bit
// operands R is at most about 45; a zero second operand goes from the
// check step straight to the result.
// A new item may be started in the cycle in which rsp_valid is high.
// Reset (synchronous, active high) returns the sequencer to idle and drops
// busy and rsp_valid; any item in progress is abandoned.
// Coefficients are kept modulo 2^32, which gives exact values for 31-bit
// operands; wider operands produce truncated results.
// ----------------------------------------------------------------------------
module extended_gcd_bezout_core
   import egcd_pkg::*;
#(
   parameter int OPERAND_WIDTH = DEFAULT_OPERAND_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [OPERAND_WIDTH-1:0]      req_first_value,
   input  logic [OPERAND_WIDTH-1:0]      req_second_value,
   output logic                          rsp_valid,
   output logic signed [COEFF_WIDTH-1:0] rsp_coeff_first,
   output logic signed [COEFF_WIDTH-1:0] rsp_coeff_second,
   output logic [DIVISOR_WIDTH-1:0]      rsp_divisor_out
);

   // Sequencer state.
   egcd_state_type state_ff, state_in;

   // Euclid working registers: remainders and both coefficient sequences.
   logic [OPERAND_WIDTH-1:0] r_prev_ff, r_prev_in;
   logic [OPERAND_WIDTH-1:0] r_cur_ff, r_cur_in;
   logic [COEFF_WIDTH-1:0]   x_prev_ff, x_prev_in;
   logic [COEFF_WIDTH-1:0]   x_cur_ff, x_cur_in;
   logic [COEFF_WIDTH-1:0]   y_prev_ff, y_prev_in;
   logic [COEFF_WIDTH-1:0]   y_cur_ff, y_cur_in;

   // Result register.
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [COEFF_WIDTH-1:0]   rsp_x_ff, rsp_x_in;
   logic [COEFF_WIDTH-1:0]   rsp_y_ff, rsp_y_in;
   logic [DIVISOR_WIDTH-1:0] rsp_d_ff, rsp_d_in;

   // Sequencer controls.
   logic accept;
   logic div_start;
   logic finish;
   logic update;

   // Shared unit interface.
   egcd_div_stat_type        div_stat;
   logic [OPERAND_WIDTH-1:0] div_rem;
   logic [COEFF_WIDTH-1:0]   prod_x;
   logic [COEFF_WIDTH-1:0]   prod_y;

   // The divider reads r_cur, x_cur and y_cur live; they hold still while
   // the sequencer waits in the divide state.
   egcd_divmac #(
      .OPERAND_WIDTH (OPERAND_WIDTH)
   ) u_divmac (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .dividend    (r_prev_ff),
      .divisor     (r_cur_ff),
      .mul_first   (x_cur_ff),
      .mul_second  (y_cur_ff),
      .stat        (div_stat),
      .remainder   (div_rem),
      .prod_first  (prod_x),
      .prod_second (prod_y)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (r_cur_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               state_in = ST_CHECK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      busy      = 1'b1;
      accept    = 1'b0;
      div_start = 1'b0;
      finish    = 1'b0;
      update    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy   = 1'b0;
            accept = start;
         end
         ST_CHECK: begin
            finish    = (r_cur_ff == '0);
            div_start = (r_cur_ff != '0);
         end
         ST_DIVIDE: begin
            update = div_stat.done;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   // Datapath: load on accept, shift one Euclid round on update. The new
   // coefficients are old - q*cur, with q*cur built by the divider.
   always_comb begin
      r_prev_in = r_prev_ff;
      r_cur_in  = r_cur_ff;
      x_prev_in = x_prev_ff;
      x_cur_in  = x_cur_ff;
      y_prev_in = y_prev_ff;
      y_cur_in  = y_cur_ff;
      if (accept) begin
         r_prev_in = req_first_value;
         r_cur_in  = req_second_value;
         x_prev_in = COEFF_WIDTH'(1);
         x_cur_in  = '0;
         y_prev_in = '0;
         y_cur_in  = COEFF_WIDTH'(1);
      end else if (update) begin
         r_prev_in = r_cur_ff;
         r_cur_in  = div_rem;
         x_prev_in = x_cur_ff;
         x_cur_in  = x_prev_ff - prod_x;
         y_prev_in = y_cur_ff;
         y_cur_in  = y_prev_ff - prod_y;
      end
   end

   // Result capture when the remainder sequence reaches zero.
   always_comb begin
      rsp_valid_in = finish;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_d_in     = rsp_d_ff;
      if (finish) begin
         rsp_x_in = x_prev_ff;
         rsp_y_in = y_prev_ff;
         rsp_d_in = DIVISOR_WIDTH'(r_prev_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      r_prev_ff <= r_prev_in;
      r_cur_ff  <= r_cur_in;
      x_prev_ff <= x_prev_in;
      x_cur_ff  <= x_cur_in;
      y_prev_ff <= y_prev_in;
      y_cur_ff  <= y_cur_in;
      rsp_x_ff  <= rsp_x_in;
      rsp_y_ff  <= rsp_y_in;
      rsp_d_ff  <= rsp_d_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_coeff_first  = $signed(rsp_x_ff);
   assign rsp_coeff_second = $signed(rsp_y_ff);
   assign rsp_divisor_out  = rsp_d_ff;

   // A result is only shown once the sequencer is back in idle.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !busy)
      else $error("result strobe while the core is busy");

   // An accepted item always makes the core busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("item accepted but core not busy");

   // The divider is never restarted while a division is running.
   assert property (@(posedge clock) disable iff (reset) div_start |-> !div_stat.active)
      else $error("divider restarted while active");

   // A finished division leaves a remainder below the divisor.
   assert property (@(posedge clock) disable iff (reset) div_stat.done |-> (div_rem < r_cur_ff))
      else $error("remainder not below divisor");

endmodule

// File: tb/extended_gcd_bezout_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Extended GCD result checker
// Watches the request and response channels of the extended GCD core, works
// out gcd and Bezout coefficients for every accepted item and compares each
// response with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module extended_gcd_bezout_checker
   import egcd_pkg::*;
#(
   parameter int OPERAND_WIDTH = DEFAULT_OPERAND_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [OPERAND_WIDTH-1:0]      req_first_value,
   input  logic [OPERAND_WIDTH-1:0]      req_second_value,
   input  logic                          rsp_valid,
   input  logic signed [COEFF_WIDTH-1:0] rsp_coeff_first,
   input  logic signed [COEFF_WIDTH-1:0] rsp_coeff_second,
   input  logic [DIVISOR_WIDTH-1:0]      rsp_divisor_out,
   output int                            mismatch_count,
   output int                            results_checked,
   output int                            gcd_outstanding
);

   typedef struct packed {
      logic [COEFF_WIDTH-1:0]   coeff_first;
      logic [COEFF_WIDTH-1:0]   coeff_second;
      logic [DIVISOR_WIDTH-1:0] divisor;
   } bezout_result_type;

   bezout_result_type pending_bezout[$];

   int fail_tally  = 0;
   int match_tally = 0;
   int open_tally  = 0;

   assign mismatch_count  = fail_tally;
   assign results_checked = match_tally;
   assign gcd_outstanding = open_tally;

   // Iterative extended Euclid; coefficients wrap modulo 2^64 and are then
   // cut down to the port widths.
   function automatic bezout_result_type solve_bezout(input logic [OPERAND_WIDTH-1:0] a,
                                                      input logic [OPERAND_WIDTH-1:0] b);
      logic [63:0]       r_prev, r_cur, x_prev, x_cur, y_prev, y_cur;
      logic [63:0]       quo, rem, x_next, y_next;
      bezout_result_type res;
      r_prev = 64'(a);
      r_cur  = 64'(b);
      x_prev = 64'd1;
      x_cur  = 64'd0;
      y_prev = 64'd0;
      y_cur  = 64'd1;
      while (r_cur != 64'd0) begin
         quo    = r_prev / r_cur;
         rem    = r_prev % r_cur;
         x_next = x_prev - quo * x_cur;
         y_next = y_prev - quo * y_cur;
         r_prev = r_cur;
         r_cur  = rem;
         x_prev = x_cur;
         x_cur  = x_next;
         y_prev = y_cur;
         y_cur  = y_next;
      end
      res.coeff_first  = x_prev[COEFF_WIDTH-1:0];
      res.coeff_second = y_prev[COEFF_WIDTH-1:0];
      res.divisor      = r_prev[DIVISOR_WIDTH-1:0];
      return res;
   endfunction

   always @(posedge clock) begin : watch_channels
      bezout_result_type want;
      int                bad;
      if (!reset) begin
         bad = 0;
         if (rsp_valid) begin
            if (pending_bezout.size() == 0) begin
               $error("Response with no item outstanding: x=%0d y=%0d d=%0d",
                      rsp_coeff_first, rsp_coeff_second, rsp_divisor_out);
               bad = 1;
            end else begin
               want = pending_bezout.pop_front();
               if (rsp_coeff_first !== $signed(want.coeff_first)) begin
                  $error("coeff_first: expected %0d, actual %0d",
                         $signed(want.coeff_first), rsp_coeff_first);
                  bad++;
               end
               if (rsp_coeff_second !== $signed(want.coeff_second)) begin
                  $error("coeff_second: expected %0d, actual %0d",
                         $signed(want.coeff_second), rsp_coeff_second);
                  bad++;
               end
               if (rsp_divisor_out !== want.divisor) begin
                  $error("divisor_out: expected %0d, actual %0d",
                         want.divisor, rsp_divisor_out);
                  bad++;
               end
               match_tally <= match_tally + 1;
            end
         end
         if (start && !busy)
            pending_bezout.push_back(solve_bezout(req_first_value, req_second_value));
         fail_tally <= fail_tally + bad;
         open_tally <= pending_bezout.size();
      end
   end

endmodule

// File: tb/extended_gcd_bezout_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Extended GCD core testbench
// Feeds operand pairs to the extended GCD core, first a directed set of
// corner cases and then a few hundred random pairs of several flavors, in
// bursts with random gaps. A checker beside the core predicts and compares
// every response; this module makes the stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module extended_gcd_bezout_core_test;
   import egcd_pkg::*;

   localparam int OPERAND_WIDTH = DEFAULT_OPERAND_WIDTH;
   localparam int RANDOM_ITEMS  = 400;
   // This bound sits several times above the run time of about 420 items at
   // the pace of the slowest item plus the largest sender gaps.
   localparam int CYCLE_LIMIT   = 3_000_000;
   localparam int DRAIN_CYCLES  = 100;

   typedef logic [OPERAND_WIDTH-1:0] operand_type;

   localparam operand_type OPERAND_MAX = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   operand_type req_first_value  = '0;
   operand_type req_second_value = '0;
   logic rsp_valid;
   logic signed [COEFF_WIDTH-1:0] rsp_coeff_first;
   logic signed [COEFF_WIDTH-1:0] rsp_coeff_second;
   logic [DIVISOR_WIDTH-1:0] rsp_divisor_out;

   int mismatch_count;
   int results_checked;
   int gcd_outstanding;

   int cycle_count   = 0;
   int items_sent    = 0;
   int burst_left    = 0;
   int zero_second   = 0;
   int first_smaller = 0;
   int equal_pairs   = 0;

   always #1 clock = ~clock;

   extended_gcd_bezout_core #(
      .OPERAND_WIDTH(OPERAND_WIDTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_first_value(req_first_value),
      .req_second_value(req_second_value),
      .rsp_valid(rsp_valid),
      .rsp_coeff_first(rsp_coeff_first),
      .rsp_coeff_second(rsp_coeff_second),
      .rsp_divisor_out(rsp_divisor_out)
   );

   extended_gcd_bezout_checker #(
      .OPERAND_WIDTH(OPERAND_WIDTH)
   ) gcd_checker (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_first_value(req_first_value),
      .req_second_value(req_second_value),
      .rsp_valid(rsp_valid),
      .rsp_coeff_first(rsp_coeff_first),
      .rsp_coeff_second(rsp_coeff_second),
      .rsp_divisor_out(rsp_divisor_out),
      .mismatch_count(mismatch_count),
      .results_checked(results_checked),
      .gcd_outstanding(gcd_outstanding)
   );

   // Watchdog: a hung handshake or a lost response ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Presents one operand pair and holds it until the core takes it. start
   // stays high on return, so a back-to-back item inside a burst is just a
   // new pair of operands with no dip in start.
   task automatic send_pair(input operand_type a, input operand_type b);
      req_first_value  <= a;
      req_second_value <= b;
      start            <= 1'b1;
      do @(posedge clock); while (busy);
      items_sent++;
      if (b == '0) zero_second++;
      if (a < b) first_smaller++;
      if (a == b) equal_pairs++;
   endtask

   // Burst pacing for the sender. At the end of a burst start is dropped
   // only when a real gap follows; with a zero gap it simply stays high.
   // About a third of the bursts run straight into the next one, which
   // gives long stretches with no idling at all.
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 11);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Consecutive Fibonacci numbers are the slowest inputs for Euclid and
   // give the largest coefficients; k = 46 is the top pair that fits.
   function automatic operand_type fibonacci(input int k);
      logic [63:0] f_lo, f_hi, f_sum;
      f_lo = 64'd0;
      f_hi = 64'd1;
      for (int i = 0; i < k; i++) begin
         f_sum = f_lo + f_hi;
         f_lo  = f_hi;
         f_hi  = f_sum;
      end
      return operand_type'(f_lo);
   endfunction

   // Draws one random operand pair. Four in ten of the pairs are plain full-width
   // values; the rest aim at the shapes that steer the algorithm: narrow
   // operands, shared factors, swapped order, zeros and equal values,
   // worst-case Fibonacci pairs and tiny divisors.
   task automatic random_pair(output operand_type a, output operand_type b);
      operand_type g, t;
      int          k;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            a = operand_type'($urandom);
            b = operand_type'($urandom);
         end
         4: begin
            a = operand_type'($urandom) >> $urandom_range(0, OPERAND_WIDTH - 1);
            b = operand_type'($urandom) >> $urandom_range(0, OPERAND_WIDTH - 1);
         end
         5: begin
            g = operand_type'($urandom_range(1, 65535));
            a = g * operand_type'($urandom_range(0, 32767));
            b = g * operand_type'($urandom_range(0, 32767));
         end
         6: begin
            a = operand_type'($urandom);
            b = operand_type'($urandom);
            if (a > b) begin
               t = a;
               a = b;
               b = t;
            end
         end
         7: begin
            a = operand_type'($urandom) >> $urandom_range(0, OPERAND_WIDTH - 1);
            case ($urandom_range(0, 2))
               0: b = '0;
               1: b = a;
               default: begin
                  b = a;
                  a = '0;
               end
            endcase
         end
         8: begin
            k = $urandom_range(2, 46);
            a = fibonacci(k);
            b = fibonacci(k - 1);
            if ($urandom_range(0, 1) == 1) begin
               t = a;
               a = b;
               b = t;
            end
         end
         default: begin
            a = operand_type'($urandom);
            b = operand_type'($urandom_range(1, 16));
         end
      endcase
   endtask

   initial begin : stimulus
      operand_type a, b;
      int          directed_count;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed corner cases: zeros on either side and on both, the
      // largest operands, unit operands, the first operand smaller than
      // the second, the worst-case Fibonacci pair in both orders, powers
      // of two and alternating bit patterns.
      send_pair('0, '0);                              pace_sender();
      send_pair(operand_type'(123456), '0);           pace_sender();
      send_pair('0, operand_type'(987654));           pace_sender();
      send_pair(OPERAND_MAX, OPERAND_MAX);            pace_sender();
      send_pair(OPERAND_MAX, '0);                     pace_sender();
      send_pair('0, OPERAND_MAX);                     pace_sender();
      send_pair(OPERAND_MAX, operand_type'(1));       pace_sender();
      send_pair(operand_type'(1), OPERAND_MAX);       pace_sender();
      send_pair(operand_type'(1), operand_type'(1));  pace_sender();
      send_pair(operand_type'(12), operand_type'(35));   pace_sender();
      send_pair(operand_type'(240), operand_type'(46));  pace_sender();
      send_pair(fibonacci(46), fibonacci(45));        pace_sender();
      send_pair(fibonacci(45), fibonacci(46));        pace_sender();
      send_pair(OPERAND_MAX, operand_type'(OPERAND_MAX - 1));
      pace_sender();
      send_pair(operand_type'(1) << (OPERAND_WIDTH - 1), operand_type'(3));
      pace_sender();
      send_pair(operand_type'(1) << (OPERAND_WIDTH - 1),
                operand_type'(1) << (OPERAND_WIDTH - 2));
      pace_sender();
      send_pair(operand_type'(32'h5555_5555), operand_type'(32'h2AAA_AAAA));
      pace_sender();
      send_pair(operand_type'(32'h2AAA_AAAA), operand_type'(32'h5555_5555));
      pace_sender();
      send_pair(operand_type'(1234567890), operand_type'(987654321));
      pace_sender();
      directed_count = items_sent;

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         random_pair(a, b);
         send_pair(a, b);
         pace_sender();
      end
      start <= 1'b0;

      // The checker publishes its outstanding count from a register, so wait
      // for a clock edge before trusting it, then wait for the last response
      // and give stray responses a little time to show up.
      @(posedge clock);
      while (gcd_outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d operand pairs (%0d directed, %0d random); %0d responses checked.",
               items_sent, directed_count, items_sent - directed_count, results_checked);
      $display("Among them %0d with a zero second operand, %0d with a smaller first, %0d equal.",
               zero_second, first_smaller, equal_pairs);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: sim.f
hdl/egcd_pkg.sv
hdl/egcd_divmac.sv
hdl/extended_gcd_bezout_core.sv
tb/extended_gcd_bezout_checker.sv
tb/extended_gcd_bezout_core_test.sv
